@@ hw/rtl/rfg_pkg.sv @@
// Shared types and constants of the Rastrigin fitness/gradient core.
package rfg_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned X_W       = 21;
  localparam int unsigned GRAD_W    = 24;
  localparam int unsigned HESS_W    = 26;
  localparam int unsigned SUM_W     = 35;
  localparam int unsigned RIDX_W    = FRAC_BITS - 2;   // folded octant angle
  localparam int unsigned Q_W       = 30;              // Q30 trig fraction

  localparam logic [Q_W:0]       Q_ONE         = {1'b1, {Q_W{1'b0}}};
  localparam logic [34:0]        TWO_PI_Q32    = 35'd26986075409;
  localparam logic [29:0]        TWENTY_PI_Q24 = 30'd1054143571;
  localparam logic [28:0]        FORTY_PI2_Q20 = 29'd413961212;
  localparam logic [SUM_W-1:0]   ACC_MAX       = '1;

  // classified element, front to back
  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic                  last;
    logic [1:0]            quad;
    logic                  swap;
    logic [RIDX_W-1:0]     ridx;
  } rfg_item_t;

  // full-turn sin/cos as sign and magnitude, plus element sideband
  typedef struct packed {
    logic [Q_W:0]          sn_mag;
    logic                  sn_neg;
    logic [Q_W:0]          cs_mag;
    logic                  cs_neg;
    logic signed [X_W-1:0] x;
    logic                  last;
  } rfg_trig_t;

endpackage

@@ hw/rtl/rfg_front.sv @@
// Front end: accepts elements, splits the phase into quadrant and folded octant angle.
module rfg_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [rfg_pkg::X_W-1:0]      in_x_value,
  input  logic                                in_last,
  output logic                                push_valid,
  input  logic                                push_ready,
  output rfg_pkg::rfg_item_t                  push_item
);

  localparam int unsigned FB = rfg_pkg::FRAC_BITS;
  localparam int unsigned RW = rfg_pkg::RIDX_W;
  localparam logic [RW-1:0] HALF = {1'b1, {(RW-1){1'b0}}};

  logic               hold_valid_r, hold_valid_nxt;
  rfg_pkg::rfg_item_t hold_item_r, hold_item_nxt;
  rfg_pkg::rfg_item_t item_cls;
  logic [FB-1:0]      phase;
  logic [RW-1:0]      plow;
  logic               fold;

  assign phase = in_x_value[FB-1:0];
  assign plow  = phase[RW-1:0];
  assign fold  = plow > HALF;

  always_comb begin
    item_cls.x    = in_x_value;
    item_cls.last = in_last;
    item_cls.quad = phase[FB-1:FB-2];
    item_cls.swap = fold;
    // past the octant edge: mirror the angle and swap sin/cos
    item_cls.ridx = fold ? (~plow + RW'(1)) : plow;
  end

  assign in_ready   = !hold_valid_r || push_ready;
  assign push_valid = hold_valid_r;
  assign push_item  = hold_item_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_item_nxt  = hold_item_r;
    if (in_ready) begin
      hold_valid_nxt = in_valid;
      if (in_valid) begin
        hold_item_nxt = item_cls;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_item_r <= hold_item_nxt;
  end

endmodule

@@ hw/rtl/rfg_queue.sv @@
// Small FIFO between front and back end.
module rfg_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  rfg_pkg::rfg_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output rfg_pkg::rfg_item_t pop_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rfg_pkg::rfg_item_t entries_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push_fire, pop_fire;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_item   = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hw/rtl/rfg_sincos.sv @@
// Pipelined octant sin/cos (Horner Taylor series in Q30) with quadrant unfolding.
module rfg_sincos (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  rfg_pkg::rfg_item_t in_item,
  output logic               out_valid,
  output rfg_pkg::rfg_trig_t out_trig
);

  localparam int unsigned QW   = rfg_pkg::Q_W;
  localparam int unsigned RW   = rfg_pkg::RIDX_W;
  localparam int unsigned NSB  = 8;                       // sideband stages before output
  localparam int unsigned T_SH = rfg_pkg::FRAC_BITS + 2;  // angle -> Q30 radians
  localparam int unsigned TP_W = RW + 35;

  // exact floor division by small constants: n < 2^30, k = 30 + ceil(log2 d)
  localparam int unsigned SH_42 = 36;
  localparam int unsigned SH_56 = 36;
  localparam int unsigned SH_20 = 35;
  localparam int unsigned SH_30 = 35;
  localparam int unsigned SH_12 = 34;
  localparam int unsigned SH_6  = 33;
  localparam logic [31:0] MG_42 = 32'(((64'd1 << SH_42) + 64'd41) / 64'd42);
  localparam logic [31:0] MG_56 = 32'(((64'd1 << SH_56) + 64'd55) / 64'd56);
  localparam logic [31:0] MG_20 = 32'(((64'd1 << SH_20) + 64'd19) / 64'd20);
  localparam logic [31:0] MG_30 = 32'(((64'd1 << SH_30) + 64'd29) / 64'd30);
  localparam logic [31:0] MG_12 = 32'(((64'd1 << SH_12) + 64'd11) / 64'd12);
  localparam logic [31:0] MG_6  = 32'(((64'd1 << SH_6)  + 64'd5)  / 64'd6);

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;

  function automatic logic [QW-1:0] mulq(input logic [QW:0] a, input logic [QW:0] b);
    logic [2*QW+1:0] p;
    p = (2*QW+2)'(a) * (2*QW+2)'(b);
    return p[2*QW-1:QW];
  endfunction

  function automatic logic [QW-1:0] divc(input logic [QW-1:0] n, input logic [31:0] m,
                                         input int unsigned k);
    logic [QW+31:0] p;
    p = (QW+32)'(n) * (QW+32)'(m);
    return QW'(p >> k);
  endfunction

  logic               vld_r [NSB+1];
  rfg_pkg::rfg_item_t item_r [NSB];

  logic [TP_W-1:0] tprod;
  logic [QW-1:0]   t1_r, t1_nxt;
  logic [QW-1:0]   t2_r, sq2_r, sq2_nxt;
  logic [QW-1:0]   t3_r, q3_r;
  logic [QW:0]     u3_r, u3_nxt, v3_r, v3_nxt;
  logic [QW-1:0]   t4_r, q4_r, ps4_r, ps4_nxt, pc4_r, pc4_nxt;
  logic [QW-1:0]   t5_r, q5_r;
  logic [QW:0]     u5_r, u5_nxt, v5_r, v5_nxt;
  logic [QW-1:0]   t6_r, q6_r, ps6_r, ps6_nxt, pc6_r, pc6_nxt;
  logic [QW-1:0]   t7_r, q7_r;
  logic [QW:0]     u7_r, u7_nxt, v7_r, v7_nxt;
  logic [QW-1:0]   so8_r, so8_nxt, pc8_r, pc8_nxt;
  logic [QW:0]     s_oct, c_oct, fa, fb;
  rfg_pkg::rfg_trig_t trig_r, trig_nxt;

  assign tprod   = TP_W'(in_item.ridx) * TP_W'(rfg_pkg::TWO_PI_Q32);
  assign t1_nxt  = QW'(tprod >> T_SH);
  assign sq2_nxt = mulq({1'b0, t1_r}, {1'b0, t1_r});
  assign u3_nxt  = rfg_pkg::Q_ONE - {1'b0, divc(sq2_r, MG_42, SH_42)};
  assign v3_nxt  = rfg_pkg::Q_ONE - {1'b0, divc(sq2_r, MG_56, SH_56)};
  assign ps4_nxt = mulq({1'b0, q3_r}, u3_r);
  assign pc4_nxt = mulq({1'b0, q3_r}, v3_r);
  assign u5_nxt  = rfg_pkg::Q_ONE - {1'b0, divc(ps4_r, MG_20, SH_20)};
  assign v5_nxt  = rfg_pkg::Q_ONE - {1'b0, divc(pc4_r, MG_30, SH_30)};
  assign ps6_nxt = mulq({1'b0, q5_r}, u5_r);
  assign pc6_nxt = mulq({1'b0, q5_r}, v5_r);
  assign u7_nxt  = rfg_pkg::Q_ONE - {1'b0, divc(ps6_r, MG_6, SH_6)};
  assign v7_nxt  = rfg_pkg::Q_ONE - {1'b0, divc(pc6_r, MG_12, SH_12)};
  assign so8_nxt = mulq({1'b0, t7_r}, u7_r);
  assign pc8_nxt = mulq({1'b0, q7_r}, v7_r);

  // last cos step is a halving, then unfold octant and quadrant
  assign s_oct = {1'b0, so8_r};
  assign c_oct = rfg_pkg::Q_ONE - {2'b00, pc8_r[QW-1:1]};
  assign fa    = item_r[NSB-1].swap ? c_oct : s_oct;
  assign fb    = item_r[NSB-1].swap ? s_oct : c_oct;

  always_comb begin
    trig_nxt.x    = item_r[NSB-1].x;
    trig_nxt.last = item_r[NSB-1].last;
    case (item_r[NSB-1].quad)
      QUAD_I: begin
        trig_nxt.sn_mag = fa; trig_nxt.sn_neg = 1'b0;
        trig_nxt.cs_mag = fb; trig_nxt.cs_neg = 1'b0;
      end
      QUAD_II: begin
        trig_nxt.sn_mag = fb; trig_nxt.sn_neg = 1'b0;
        trig_nxt.cs_mag = fa; trig_nxt.cs_neg = 1'b1;
      end
      QUAD_III: begin
        trig_nxt.sn_mag = fa; trig_nxt.sn_neg = 1'b1;
        trig_nxt.cs_mag = fb; trig_nxt.cs_neg = 1'b1;
      end
      default: begin
        trig_nxt.sn_mag = fb; trig_nxt.sn_neg = 1'b1;
        trig_nxt.cs_mag = fa; trig_nxt.cs_neg = 1'b0;
      end
    endcase
  end

  assign out_valid = vld_r[NSB];
  assign out_trig  = trig_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NSB; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i <= NSB; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r[0] <= in_item;
      for (int i = 1; i < NSB; i++) begin
        item_r[i] <= item_r[i-1];
      end
      t1_r   <= t1_nxt;
      t2_r   <= t1_r;   sq2_r <= sq2_nxt;
      t3_r   <= t2_r;   q3_r  <= sq2_r;  u3_r  <= u3_nxt;  v3_r  <= v3_nxt;
      t4_r   <= t3_r;   q4_r  <= q3_r;   ps4_r <= ps4_nxt; pc4_r <= pc4_nxt;
      t5_r   <= t4_r;   q5_r  <= q4_r;   u5_r  <= u5_nxt;  v5_r  <= v5_nxt;
      t6_r   <= t5_r;   q6_r  <= q5_r;   ps6_r <= ps6_nxt; pc6_r <= pc6_nxt;
      t7_r   <= t6_r;   q7_r  <= q6_r;   u7_r  <= u7_nxt;  v7_r  <= v7_nxt;
      so8_r  <= so8_nxt; pc8_r <= pc8_nxt;
      trig_r <= trig_nxt;
    end
  end

endmodule

@@ hw/rtl/rfg_back.sv @@
// Back end: sin/cos pipeline, scaling, saturating fitness accumulator, output register.
module rfg_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  pop_valid,
  output logic                                  pop_ready,
  input  rfg_pkg::rfg_item_t                    pop_item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [rfg_pkg::GRAD_W-1:0]     out_grad_term,
  output logic signed [rfg_pkg::HESS_W-1:0]     out_hess_term,
  output logic [rfg_pkg::SUM_W-1:0]             out_fitness_sum,
  output logic                                  out_fitness_valid,
  output logic                                  out_saturated,
  output logic                                  out_last_out
);

  localparam int unsigned FB   = rfg_pkg::FRAC_BITS;
  localparam int unsigned QW   = rfg_pkg::Q_W;
  localparam int unsigned XW   = rfg_pkg::X_W;
  localparam int unsigned GW   = rfg_pkg::GRAD_W;
  localparam int unsigned HW   = rfg_pkg::HESS_W;
  localparam int unsigned SW   = rfg_pkg::SUM_W;
  localparam int unsigned G_SH = QW + 24 - FB;
  localparam int unsigned H_SH = QW + 20 - FB;
  localparam int unsigned F_SH = QW - FB;
  localparam int unsigned GP_W = QW + 1 + 30;
  localparam int unsigned HP_W = QW + 1 + 29;
  localparam int unsigned FP_W = QW + 2 + 4;
  localparam int unsigned XP_W = 2 * XW;
  localparam int unsigned GM_W = GP_W - G_SH;
  localparam int unsigned HM_W = HP_W - H_SH;
  localparam int unsigned FC_W = FP_W - F_SH;
  localparam int unsigned SQ_W = XP_W - FB;
  localparam int unsigned TM_W = SQ_W + 1;

  logic               en;
  logic               trig_valid;
  rfg_pkg::rfg_trig_t trig;
  logic               out_valid_r, out_valid_nxt;

  assign en        = !out_valid_r || out_ready;
  assign pop_ready = en;

  rfg_sincos u_sincos (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pop_valid),
    .in_item   (pop_item),
    .out_valid (trig_valid),
    .out_trig  (trig)
  );

  // stage 1: constant scaling and x^2, magnitudes rounded half away from zero
  logic [GP_W-1:0]  gprod;
  logic [HP_W-1:0]  hprod;
  logic [QW+1:0]    cdiff;
  logic [FP_W-1:0]  fprod;
  logic [XW-1:0]    xmag;
  logic [XP_W-1:0]  xsq;
  logic             b1_valid_r;
  logic [GM_W-1:0]  gmag_r, gmag_nxt;
  logic [HM_W-1:0]  hmag_r, hmag_nxt;
  logic [FC_W-1:0]  fc_r, fc_nxt;
  logic [SQ_W-1:0]  sq_r, sq_nxt;
  logic             sn_neg_r, cs_neg_r, last1_r;
  logic signed [XW-1:0] x1_r;

  assign gprod = GP_W'(trig.sn_mag) * GP_W'(rfg_pkg::TWENTY_PI_Q24);
  assign hprod = HP_W'(trig.cs_mag) * HP_W'(rfg_pkg::FORTY_PI2_Q20);
  assign cdiff = trig.cs_neg ? ((QW+2)'(rfg_pkg::Q_ONE) + (QW+2)'(trig.cs_mag))
                             : ((QW+2)'(rfg_pkg::Q_ONE) - (QW+2)'(trig.cs_mag));
  assign fprod = FP_W'(cdiff) * FP_W'(10);
  assign xmag  = trig.x[XW-1] ? (~trig.x + XW'(1)) : trig.x;
  assign xsq   = XP_W'(xmag) * XP_W'(xmag);

  assign gmag_nxt = GM_W'((gprod + (GP_W'(1) << (G_SH - 1))) >> G_SH);
  assign hmag_nxt = HM_W'((hprod + (HP_W'(1) << (H_SH - 1))) >> H_SH);
  assign fc_nxt   = FC_W'((fprod + (FP_W'(1) << (F_SH - 1))) >> F_SH);
  assign sq_nxt   = SQ_W'((xsq + (XP_W'(1) << (FB - 1))) >> FB);

  // stage 2: signed gradient / Hessian terms, per-element fitness term
  logic [GW-1:0]    xext, gterm;
  logic [HW-1:0]    hterm;
  logic             b2_valid_r;
  logic [GW-1:0]    grad_r, grad_nxt;
  logic [HW-1:0]    hess_r, hess_nxt;
  logic [TM_W-1:0]  term_r, term_nxt;
  logic             last2_r;

  assign xext     = {{(GW - XW){x1_r[XW-1]}}, x1_r};
  assign gterm    = sn_neg_r ? (~GW'(gmag_r) + GW'(1)) : GW'(gmag_r);
  assign hterm    = cs_neg_r ? (~HW'(hmag_r) + HW'(1)) : HW'(hmag_r);
  assign grad_nxt = {xext[GW-2:0], 1'b0} + gterm;
  assign hess_nxt = (HW'(2) << FB) + hterm;
  assign term_nxt = TM_W'(sq_r) + TM_W'(fc_r);

  // stage 3: accumulate with saturation, load output register
  logic [SW:0]      acc_sum;
  logic             acc_hit;
  logic [SW-1:0]    acc_new;
  logic             ovf_new;
  logic [SW-1:0]    partial_r, partial_nxt;
  logic             ovf_r, ovf_nxt;
  logic [GW-1:0]    o_grad_r;
  logic [HW-1:0]    o_hess_r;
  logic [SW-1:0]    o_sum_r, o_sum_nxt;
  logic             o_sat_r, o_last_r;
  logic             load;

  assign load    = en && b2_valid_r;
  assign acc_sum = {1'b0, partial_r} + (SW+1)'(term_r);
  assign acc_hit = acc_sum >= {1'b0, rfg_pkg::ACC_MAX};
  assign acc_new = acc_hit ? rfg_pkg::ACC_MAX : acc_sum[SW-1:0];
  assign ovf_new = ovf_r || acc_hit;

  always_comb begin
    partial_nxt   = partial_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    o_sum_nxt     = last2_r ? acc_new : '0;
    if (en) begin
      out_valid_nxt = b2_valid_r;
    end
    if (load) begin
      // last element of a vector reports the sum and restarts the accumulator
      partial_nxt = last2_r ? '0 : acc_new;
      ovf_nxt     = last2_r ? 1'b0 : ovf_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      b2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      partial_r   <= '0;
      ovf_r       <= 1'b0;
    end else begin
      if (en) begin
        b1_valid_r <= trig_valid;
        b2_valid_r <= b1_valid_r;
      end
      out_valid_r <= out_valid_nxt;
      partial_r   <= partial_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gmag_r   <= gmag_nxt;
      hmag_r   <= hmag_nxt;
      fc_r     <= fc_nxt;
      sq_r     <= sq_nxt;
      sn_neg_r <= trig.sn_neg;
      cs_neg_r <= trig.cs_neg;
      x1_r     <= trig.x;
      last1_r  <= trig.last;
      grad_r   <= grad_nxt;
      hess_r   <= hess_nxt;
      term_r   <= term_nxt;
      last2_r  <= last1_r;
      o_grad_r <= grad_r;
      o_hess_r <= hess_r;
      o_sum_r  <= o_sum_nxt;
      o_sat_r  <= ovf_new;
      o_last_r <= last2_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_grad_term     = signed'(o_grad_r);
  assign out_hess_term     = signed'(o_hess_r);
  assign out_fitness_sum   = o_sum_r;
  assign out_fitness_valid = o_last_r;
  assign out_saturated     = o_sat_r;
  assign out_last_out      = o_last_r;

endmodule

@@ hw/rtl/rastrigin_fitness_gradient_core.sv @@
// Top level of the Rastrigin fitness, gradient and diagonal Hessian core.
//
//  channel | dir | handshake              | beat contents
//  --------+-----+------------------------+------------------------------------------
//  in_     | in  | in_valid / in_ready    | x_value (s21, 16 frac bits), last
//  out_    | out | out_valid / out_ready  | grad_term, hess_term, fitness_sum,
//          |     |                        | fitness_valid, saturated, last_out
//
// One beat per clock while out_ready stays high; one result beat per input beat, in
// order. A beat passes the front register, the queue and the sin/cos pipeline of
// nine stages (angle scaling, squaring, six divide or multiply steps on each of the
// sine and cosine Horner chains, unfold), then three scaling/accumulate stages.
// Reset (rst_n, synchronous, active low) empties the front register, the queue and
// every pipeline stage, and clears the fitness accumulator and its saturation flag.
// With out_ready low and out_valid high the back end freezes; the front register
// plus the QUEUE_DEPTH-entry queue take beats until full, then in_ready drops.
module rastrigin_fitness_gradient_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [rfg_pkg::X_W-1:0]        in_x_value,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [rfg_pkg::GRAD_W-1:0]     out_grad_term,
  output logic signed [rfg_pkg::HESS_W-1:0]     out_hess_term,
  output logic [rfg_pkg::SUM_W-1:0]             out_fitness_sum,
  output logic                                  out_fitness_valid,
  output logic                                  out_saturated,
  output logic                                  out_last_out
);

  // front -> queue
  logic               push_valid;
  logic               push_ready;
  rfg_pkg::rfg_item_t push_item;

  // queue -> back
  logic               pop_valid;
  logic               pop_ready;
  rfg_pkg::rfg_item_t pop_item;

  // front: registers the beat and folds the phase into quadrant + octant angle
  rfg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_x_value (in_x_value),
    .in_last    (in_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decouples front from back so either side can stall alone
  rfg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // back: sin/cos, gradient/Hessian scaling, saturating fitness sum, output register
  rfg_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_item          (pop_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_grad_term     (out_grad_term),
    .out_hess_term     (out_hess_term),
    .out_fitness_sum   (out_fitness_sum),
    .out_fitness_valid (out_fitness_valid),
    .out_saturated     (out_saturated),
    .out_last_out      (out_last_out)
  );

endmodule

@@ verif/rastrigin_fitness_gradient_core_test.sv @@
// Self-checking testbench for the Rastrigin fitness, gradient and Hessian core.
`timescale 1ns / 100ps

// Tracks the expected result beats of the core and compares what comes out.
class fitness_scoreboard;

  typedef struct {
    logic [rfg_pkg::GRAD_W-1:0] grad;
    logic [rfg_pkg::HESS_W-1:0] hess;
    logic [rfg_pkg::SUM_W-1:0]  fitness;
    logic                       fitness_vld;
    logic                       sat;
    logic                       last;
  } element_result_t;

  localparam longint unsigned Q30_UNIT  = 64'd1 << 30;
  localparam longint unsigned TURN_Q32  = 64'd26986075409;
  localparam longint unsigned GRAD_GAIN = 64'd1054143571;  // 20*pi, Q24
  localparam longint unsigned HESS_GAIN = 64'd413961212;   // 40*pi^2, Q20
  localparam longint unsigned SUM_CEIL  = (64'd1 << rfg_pkg::SUM_W) - 1;

  element_result_t    pending_results[$];
  longint unsigned    running_sum;
  bit                 sum_saturated;
  int unsigned        failures;

  function new();
    running_sum   = 0;
    sum_saturated = 0;
    failures      = 0;
  endfunction

  function void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
  endfunction

  function longint unsigned round_shift(longint unsigned v, int n);
    return (v + (64'd1 << (n - 1))) >> n;
  endfunction

  // signed Q30 times constant, magnitude rounded half away from zero
  function longint scale_q30(longint v, longint unsigned k, int n);
    longint unsigned mag;
    longint unsigned p;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    p   = round_shift(mag * k, n);
    return (v < 0) ? -longint'(p) : longint'(p);
  endfunction

  // first octant, r in 2^-24 turn; truncating Horner series in Q30
  function void octant_trig(input longint unsigned r,
                            output longint unsigned s, output longint unsigned c);
    longint unsigned t, t2, u, v;
    t  = (r * TURN_Q32) >> 26;
    t2 = (t * t) >> 30;
    u  = Q30_UNIT - t2 / 42;
    u  = Q30_UNIT - ((t2 * u) >> 30) / 20;
    u  = Q30_UNIT - ((t2 * u) >> 30) / 6;
    s  = (t * u) >> 30;
    v  = Q30_UNIT - t2 / 56;
    v  = Q30_UNIT - ((t2 * v) >> 30) / 30;
    v  = Q30_UNIT - ((t2 * v) >> 30) / 12;
    v  = Q30_UNIT - ((t2 * v) >> 30) / 2;
    c  = v;
  endfunction

  function void turn_trig(input longint unsigned phase, output longint sn, output longint cs);
    longint unsigned a, r, s, c;
    logic [1:0]      quad;
    a    = (phase << (24 - rfg_pkg::FRAC_BITS)) & 64'hFF_FFFF;
    quad = a[23:22];
    r    = a & 64'h3F_FFFF;
    if (r > (64'd1 << 21)) octant_trig((64'd1 << 22) - r, c, s);
    else                   octant_trig(r, s, c);
    case (quad)
      2'd0: begin sn =  longint'(s); cs =  longint'(c); end
      2'd1: begin sn =  longint'(c); cs = -longint'(s); end
      2'd2: begin sn = -longint'(s); cs = -longint'(c); end
      default: begin sn = -longint'(c); cs = longint'(s); end
    endcase
  endfunction

  // accepted input beat: predict its result and update the running fitness
  function void note_element(logic signed [rfg_pkg::X_W-1:0] x, logic last);
    element_result_t r;
    longint          xv, sn, cs, grad, hess;
    longint unsigned mag, term;
    xv = x;
    turn_trig(longint'(xv) & 64'hFFFF, sn, cs);
    grad = 2 * xv + scale_q30(sn, GRAD_GAIN, 38);
    hess = (longint'(2) << rfg_pkg::FRAC_BITS) + scale_q30(cs, HESS_GAIN, 34);
    mag  = (xv < 0) ? longint'(-xv) : longint'(xv);
    term = round_shift(mag * mag, rfg_pkg::FRAC_BITS) +
           round_shift((Q30_UNIT - longint'(cs)) * 10, 30 - rfg_pkg::FRAC_BITS);
    running_sum = running_sum + term;
    if (running_sum >= SUM_CEIL) begin
      running_sum   = SUM_CEIL;
      sum_saturated = 1'b1;
    end
    r.grad        = grad[rfg_pkg::GRAD_W-1:0];
    r.hess        = hess[rfg_pkg::HESS_W-1:0];
    r.fitness     = last ? running_sum[rfg_pkg::SUM_W-1:0] : '0;
    r.fitness_vld = last;
    r.sat         = sum_saturated;
    r.last        = last;
    pending_results = {pending_results, r};
    if (last) begin
      running_sum   = 0;
      sum_saturated = 1'b0;
    end
  endfunction

  function void check_beat(logic [rfg_pkg::GRAD_W-1:0] grad, logic [rfg_pkg::HESS_W-1:0] hess,
                           logic [rfg_pkg::SUM_W-1:0] fitness, logic fitness_vld,
                           logic sat, logic last);
    element_result_t e;
    if (pending_results.size() == 0) begin
      note_failure("result beat with nothing outstanding");
      return;
    end
    e = pending_results.pop_front();
    if (grad !== e.grad || hess !== e.hess || fitness !== e.fitness ||
        fitness_vld !== e.fitness_vld || sat !== e.sat || last !== e.last)
      note_failure($sformatf({"exp grad=%h hess=%h fit=%h fv=%b sat=%b last=%b, ",
                              "got grad=%h hess=%h fit=%h fv=%b sat=%b last=%b"},
                             e.grad, e.hess, e.fitness, e.fitness_vld, e.sat, e.last,
                             grad, hess, fitness, fitness_vld, sat, last));
  endfunction

endclass

module rastrigin_fitness_gradient_core_test;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic signed [rfg_pkg::X_W-1:0]     in_x_value = '0;
  logic                               in_last = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [rfg_pkg::GRAD_W-1:0]  out_grad_term;
  logic signed [rfg_pkg::HESS_W-1:0]  out_hess_term;
  logic [rfg_pkg::SUM_W-1:0]          out_fitness_sum;
  logic                               out_fitness_valid;
  logic                               out_saturated;
  logic                               out_last_out;

  // when set, neither side idles
  bit                                 quiet_stretch = 1'b0;
  fitness_scoreboard                  sb = new();

  rastrigin_fitness_gradient_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_x_value        (in_x_value),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_grad_term     (out_grad_term),
    .out_hess_term     (out_hess_term),
    .out_fitness_sum   (out_fitness_sum),
    .out_fitness_valid (out_fitness_valid),
    .out_saturated     (out_saturated),
    .out_last_out      (out_last_out)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop; the slowest legal run is well under a tenth of this.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side. Values read right after the edge are the pre-edge ones, so
  // the handshake is sampled exactly as the core saw it. Stalls come in short
  // bursts, about 6% of cycles overall, except during a quiet stretch.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_beat(out_grad_term, out_hess_term, out_fitness_sum,
                      out_fitness_valid, out_saturated, out_last_out);
      if (hold_left > 0) begin
        hold_left--;
      end else if (!quiet_stretch && $urandom_range(99) < 3) begin
        hold_left = $urandom_range(1, 3);
      end
      out_ready <= rst_n && (hold_left == 0);
    end
  end

  // One element beat; an occasional gap of a few cycles goes in front of it.
  // valid stays high straight into the next beat when there is no gap.
  task automatic send_element(input logic signed [rfg_pkg::X_W-1:0] x, input logic last_flag);
    if (!quiet_stretch && $urandom_range(99) < 3) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_x_value <= x;
    in_last    <= last_flag;
    do @(posedge clk); while (!in_ready);
    sb.note_element(x, last_flag);
  endtask

  // Sender holds off until every outstanding result beat is back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // Mix of full-range values, small values around zero and values whose
  // phase sits on a quadrant or octant edge of the sin/cos fold.
  function automatic logic signed [rfg_pkg::X_W-1:0] random_element();
    int          pick;
    int          v;
    int unsigned edge_phase[8] = '{0, 'h2000, 'h2001, 'h1FFF, 'h4000, 'h8000, 'hC000, 'hFFFF};
    pick = $urandom_range(99);
    if (pick < 55)      v = $urandom_range(0, 2097151);
    else if (pick < 85) v = int'($urandom_range(0, 524287)) - 262144;
    else                v = (int'($urandom_range(0, 31)) - 16) * 65536 +
                            int'(edge_phase[$urandom_range(7)]);
    return v[rfg_pkg::X_W-1:0];
  endfunction

  initial begin
    logic signed [rfg_pkg::X_W-1:0] x;
    int unsigned                    vec_len, mag;
    int                             sent;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // single-element vector at zero: fitness comes out as exactly zero
    send_element(21'sd0, 1'b1);
    // one vector through the field extremes and every quadrant/octant edge
    send_element(-21'sd1048576, 1'b0);
    send_element(21'sd1048575, 1'b0);
    send_element(21'sd65536, 1'b0);
    send_element(-21'sd65536, 1'b0);
    send_element(21'sd1, 1'b0);
    send_element(-21'sd1, 1'b0);
    send_element(21'sh2000, 1'b0);   // octant edge, no swap
    send_element(21'sh2001, 1'b0);   // just past it, sin/cos swapped
    send_element(21'sh3FFF, 1'b0);
    send_element(21'sh4000, 1'b0);   // quarter turn
    send_element(21'sh6000, 1'b0);
    send_element(21'sh8000, 1'b0);   // half turn, cos = -1
    send_element(21'shA000, 1'b0);
    send_element(21'shC000, 1'b0);   // three quarter turn
    send_element(21'shE000, 1'b0);
    send_element(21'shFFFF, 1'b0);
    send_element(-21'sh8000, 1'b0);
    send_element(21'sh54000, 1'b1);
    // lone extremes as their own vectors
    send_element(21'sd1048575, 1'b1);
    send_element(-21'sd1048576, 1'b1);

    wait_for_drain();

    // --- saturation ---
    // Over two thousand values near +/-15.58, where x^2 + 10 - 10cos is
    // close to its peak (about 261.5 per element): the sum hits its ceiling a
    // few elements before the end, then a short random tail keeps it pinned.
    // The middle of the vector runs with no idling on either side.
    for (int i = 0; i < 2020; i++) begin
      quiet_stretch = (i >= 400) && (i < 1600);
      if (i < 2012) begin
        mag = $urandom_range(1020400, 1021700);
        x   = $urandom_range(1) ? mag[rfg_pkg::X_W-1:0] : -mag[rfg_pkg::X_W-1:0];
      end else begin
        x = random_element();
      end
      send_element(x, i == 2019);
    end
    quiet_stretch = 1'b0;
    // next vector must start from a cleared sum and flag
    send_element(21'sd65536, 1'b1);

    wait_for_drain();

    // --- random vectors ---
    sent = 0;
    while (sent < 40) begin
      vec_len = ($urandom_range(9) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 12);
      for (int i = 0; i < vec_len; i++) send_element(random_element(), i == vec_len - 1);
      sent += vec_len;
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    // give stray beats time to show up
    repeat (40) @(posedge clk);
    if (sb.pending_results.size() != 0) sb.note_failure("result beats never arrived");

    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/rfg_pkg.sv
hw/rtl/rfg_front.sv
hw/rtl/rfg_queue.sv
hw/rtl/rfg_sincos.sv
hw/rtl/rfg_back.sv
hw/rtl/rastrigin_fitness_gradient_core.sv
verif/rastrigin_fitness_gradient_core_test.sv
